// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL of the integer field formatter.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ifmt_pkg.sv =====
// Shared types and constants of the integer field formatter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ifmt_pkg;

  // Default saturation limit of the field width
  localparam int DefMaxFieldWidth = 64;

  // Decimal digits of a 64-bit magnitude, and bits of that digit store
  localparam int NumDigits = 20;
  localparam int DigitBits = 4 * NumDigits;

  // Entries of the queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);

  // Command codes (carried on tuser)
  localparam logic [2:0] CMD_SDEC = 3'd0;
  localparam logic [2:0] CMD_UDEC = 3'd1;
  localparam logic [2:0] CMD_HEXL = 3'd2;
  localparam logic [2:0] CMD_HEXU = 3'd3;
  localparam logic [2:0] CMD_PTR  = 3'd4;

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef logic [NumDigits-1:0][3:0] digit_vec_t;

  // Everything the back end needs to emit one field
  typedef struct packed {
    logic       pre_en;     // sign character ahead of any fill
    logic [7:0] pre_char;
    logic [6:0] lead;       // fill characters before the string
    logic [6:0] trail;      // fill characters after the string
    logic [7:0] fill_char;
    logic [1:0] plen;       // prefix characters at the start of the string
    logic [7:0] p0;
    logic [7:0] p1;
    logic [4:0] slen;       // string length after the precision cut, at least 1
    digit_vec_t digits;     // least significant digit at index 0
    logic [4:0] ndig;       // significant digits, at least 1
    logic       upper;      // upper-case hex letters
  } plan_t;

endpackage

`default_nettype wire

// ===== sv/ifmt_queue.sv =====
// Two-entry queue of field plans between front and back end.
// Depends on ifmt_pkg for plan_t and the queue depth.
`default_nettype none

module ifmt_queue
  import ifmt_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  plan_t          in_plan,
  output logic           out_valid,
  input  logic           out_ready,
  output plan_t          out_plan,
  output logic [QPtrW:0] count
);

  plan_t            mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic             push;
  logic             pop;

  assign in_ready  = (count != (QPtrW + 1)'(QDepth));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_plan  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_plan;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/ifmt_front.sv =====
// Front end: accepts an item, converts decimal magnitudes to digits and
// builds the field plan. Depends on ifmt_pkg.
`default_nettype none

module ifmt_front
  import ifmt_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = DefMaxFieldWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [63:0] value,
  input  logic        wide_value,
  input  logic [6:0]  field_width,
  input  logic [6:0]  precision,
  input  logic        left_align,
  input  logic        show_sign,
  input  logic        zero_pad,
  output logic        plan_valid,
  input  logic        plan_ready,
  output plan_t       plan
);

  localparam logic [6:0] MaxW = 7'(MAX_FIELD_WIDTH);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t         state;
  logic [2:0]           cmd;
  logic [63:0]          bits;
  logic [DigitBits-1:0] digits;
  logic [DigitBits-1:0] digits_next;
  logic [63:0]          bits_next;
  logic [3:0]           step;
  logic [6:0]           width_eff;
  logic [6:0]           prec;
  logic                 left;
  logic                 sign;
  logic                 zero;
  logic                 pre_en;
  logic                 neg;

  // Accept-side decode
  logic [63:0] sext;
  logic [63:0] zext;
  logic [63:0] mag;
  logic        is_sdec;
  logic        in_neg;
  logic        in_pre;
  logic [6:0]  w_sat;
  logic [6:0]  w_adj;
  logic        cmd_ok;
  logic        is_dec;

  // Plan-side decode
  logic [4:0]  ndig;
  logic [1:0]  plen;
  logic [4:0]  full_len;
  logic [4:0]  slen;
  logic [6:0]  fill_n;
  logic        is_hex;

  assign in_ready = (state == F_IDLE);

  always_comb begin
    sext    = wide_value ? value : {{32{value[31]}}, value[31:0]};
    zext    = wide_value ? value : {32'd0, value[31:0]};
    is_sdec = (command == CMD_SDEC);
    in_neg  = is_sdec && sext[63];
    mag     = in_neg ? (~sext + 64'd1) : (is_sdec ? sext : zext);
    in_pre  = is_sdec && (in_neg || show_sign);
    w_sat   = (field_width > MaxW) ? MaxW : field_width;
    w_adj   = (in_pre && (w_sat > 7'd1)) ? (w_sat - 7'd1) : w_sat;
    cmd_ok  = (command <= CMD_PTR);
    is_dec  = (command == CMD_SDEC) || (command == CMD_UDEC);
  end

  // Four double-dabble steps per cycle: correct each digit, then shift in a bit
  always_comb begin
    digits_next = digits;
    bits_next   = bits;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (digits_next[4*i +: 4] >= 4'd5) begin
          digits_next[4*i +: 4] = digits_next[4*i +: 4] + 4'd3;
        end
      end
      digits_next = {digits_next[DigitBits-2:0], bits_next[63]};
      bits_next   = {bits_next[62:0], 1'b0};
    end
  end

  always_comb begin
    ndig = 5'd1;
    for (int i = 1; i < NumDigits; i++) begin
      if (digits[4*i +: 4] != 4'd0) begin
        ndig = 5'(i + 1);
      end
    end
    is_hex = (cmd == CMD_HEXL) || (cmd == CMD_HEXU);
    if ((cmd == CMD_UDEC) && sign) begin
      plen = 2'd1;
    end else if (cmd == CMD_PTR) begin
      plen = 2'd2;
    end else begin
      plen = 2'd0;
    end
    full_len = {3'd0, plen} + ndig;
    if (!is_hex && (prec != 7'd0) && (prec < {2'd0, full_len})) begin
      slen = prec[4:0];
    end else begin
      slen = full_len;
    end
    fill_n = (width_eff > {2'd0, slen}) ? (width_eff - {2'd0, slen}) : 7'd0;

    plan.pre_en    = pre_en;
    plan.pre_char  = neg ? CH_MINUS : CH_PLUS;
    plan.lead      = (is_hex || !left) ? fill_n : 7'd0;
    plan.trail     = (is_hex || !left) ? 7'd0 : fill_n;
    plan.fill_char = zero ? CH_ZERO : CH_SPACE;
    plan.plen      = plen;
    plan.p0        = (cmd == CMD_PTR) ? CH_ZERO : CH_PLUS;
    plan.p1        = CH_X;
    plan.slen      = slen;
    plan.digits    = digits;
    plan.ndig      = ndig;
    plan.upper     = (cmd == CMD_HEXU);
  end

  assign plan_valid = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && cmd_ok) begin
            state <= is_dec ? F_CONV : F_PUSH;
          end
        end
        F_CONV: begin
          if (step == 4'd15) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (plan_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == F_IDLE) && in_valid) begin
      cmd       <= command;
      bits      <= mag;
      digits    <= is_dec ? '0 : {{(DigitBits - 64){1'b0}}, zext};
      step      <= 4'd0;
      width_eff <= w_adj;
      prec      <= precision;
      left      <= left_align;
      sign      <= show_sign;
      zero      <= zero_pad;
      pre_en    <= in_pre;
      neg       <= in_neg;
    end else if (state == F_CONV) begin
      digits <= digits_next;
      bits   <= bits_next;
      step   <= step + 4'd1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ifmt_back.sv =====
// Back end: walks a field plan and emits one character per cycle while out_ready
// does not hold it back, through a registered output stage. Depends on ifmt_pkg.
`default_nettype none

module ifmt_back
  import ifmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       plan_valid,
  output logic       plan_ready,
  input  plan_t      plan,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_PRE   = 5'b00010,
    PH_LEAD  = 5'b00100,
    PH_STR   = 5'b01000,
    PH_TRAIL = 5'b10000
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  plan_t      cur;
  logic [6:0] cnt;
  logic       emit;
  logic       seg_end;
  logic       last;
  logic [7:0] ch;
  logic [4:0] didx;
  logic [3:0] dig;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CH_UA : CH_LA;
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return base + {4'd0, d} - 8'd10;
  endfunction

  assign plan_ready = (phase == PH_IDLE);
  assign emit       = (phase != PH_IDLE) && (!out_valid || out_ready);

  always_comb begin
    didx = cur.ndig - 5'd1 - (cnt[4:0] - {3'd0, cur.plen});
    dig  = cur.digits[didx];
    unique case (phase)
      PH_PRE: begin
        ch         = cur.pre_char;
        seg_end    = 1'b1;
        phase_next = (cur.lead != 7'd0) ? PH_LEAD : PH_STR;
      end
      PH_LEAD: begin
        ch         = cur.fill_char;
        seg_end    = (cnt == cur.lead - 7'd1);
        phase_next = PH_STR;
      end
      PH_STR: begin
        if (cnt < {5'd0, cur.plen}) begin
          ch = cnt[0] ? cur.p1 : cur.p0;
        end else begin
          ch = digit_char(dig, cur.upper);
        end
        seg_end    = (cnt == {2'd0, cur.slen} - 7'd1);
        phase_next = (cur.trail != 7'd0) ? PH_TRAIL : PH_IDLE;
      end
      PH_TRAIL: begin
        ch         = cur.fill_char;
        seg_end    = (cnt == cur.trail - 7'd1);
        phase_next = PH_IDLE;
      end
      default: begin
        ch         = CH_SPACE;
        seg_end    = 1'b0;
        phase_next = PH_IDLE;
      end
    endcase
    last = seg_end && (phase_next == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((phase == PH_IDLE) && plan_valid) begin
        if (plan.pre_en) begin
          phase <= PH_PRE;
        end else if (plan.lead != 7'd0) begin
          phase <= PH_LEAD;
        end else begin
          phase <= PH_STR;
        end
      end else if (emit && seg_end) begin
        phase <= phase_next;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((phase == PH_IDLE) && plan_valid) begin
      cur <= plan;
      cnt <= 7'd0;
    end else if (emit) begin
      cnt <= seg_end ? 7'd0 : (cnt + 7'd1);
    end
    if (emit) begin
      out_char <= ch;
      out_last <= last;
    end
  end

endmodule

`default_nettype wire

// ===== sv/integer_field_formatter.sv =====
// Integer field formatter: decimal commands run through digit conversion in the front
// end before their plan is queued; hex and pointer commands skip the conversion.
// Throughput: one character per cycle at the output while m_tready allows; the front
// end takes no new item until its plan is queued, nor the back end until a field is out.
// Reset: synchronous rst empties the queue and idles both ends; nothing else clears.
`default_nettype none

`include "assert_macros.svh"

module integer_field_formatter
  import ifmt_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = DefMaxFieldWidth
) (
  input  logic        clk,
  input  logic        rst,
  // Input item transaction
  input  logic        s_tvalid,
  output logic        s_tready,
  // [63:0] value, [64] wide_value, [71:65] field_width, [78:72] precision,
  // [79] left_align, [80] show_sign, [81] zero_pad, [87:82] zero
  input  logic [87:0] s_tdata,
  // [2:0] command
  input  logic [2:0]  s_tuser,
  // Output character transaction
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] out_char
  output logic [7:0]  m_tdata,
  output logic        m_tlast
);

  // Plan hand-off from front to queue, and from queue to back
  plan_t          f_plan;
  logic           f_valid;
  logic           f_ready;
  plan_t          b_plan;
  logic           b_valid;
  logic           b_ready;
  logic [QPtrW:0] q_count;
  // Input transaction carrying a command that produces a field
  logic           s_cmd_take;

  assign s_cmd_take = s_tvalid && s_tready && (s_tuser <= CMD_PTR);

  // Front: accept the item, drop unused commands, convert and plan the field.
  // Decimal values run through a 4-bit-per-cycle double-dabble converter.
  ifmt_front #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .command    (s_tuser),
    .value      (s_tdata[63:0]),
    .wide_value (s_tdata[64]),
    .field_width(s_tdata[71:65]),
    .precision  (s_tdata[78:72]),
    .left_align (s_tdata[79]),
    .show_sign  (s_tdata[80]),
    .zero_pad   (s_tdata[81]),
    .plan_valid (f_valid),
    .plan_ready (f_ready),
    .plan       (f_plan)
  );

  // Queue: hold finished plans so conversion of the next item overlaps emission
  ifmt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_plan  (f_plan),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_plan (b_plan),
    .count    (q_count)
  );

  // Back: sign, leading fill, prefix and digits, trailing fill, in that order
  ifmt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .plan_valid(b_valid),
    .plan_ready(b_ready),
    .plan      (b_plan),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast)
  );

  // Queue occupancy never exceeds its depth
  `ASSERT_IMPLIES(a_queue_depth, clk, rst, 1'b1, q_count <= QDepth, "queue overflow")

  // Accepting a valid command makes the front end not ready
  `ASSERT_NEXT(a_front_busy, clk, rst, s_cmd_take, !s_tready, "front accepted twice")

  // Every emitted character is non-null
  `ASSERT_IMPLIES(a_char_nonzero, clk, rst, m_tvalid, m_tdata != 8'h00, "null character emitted")

endmodule

`default_nettype wire
